// ----- rtl/printf_spec_parser_macros.svh -----
// ----------------------------------------------------------------------------
// printf_spec_parser_macros.svh
// Assertion macros for the format specification parser. They compile to
// nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef PRINTF_SPEC_PARSER_MACROS_SVH
`define PRINTF_SPEC_PARSER_MACROS_SVH

`ifndef SYNTH
// same-cycle implication, sampled on clk, off during reset
`define PSP_ASSERT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication, sampled on clk, off during reset
`define PSP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define PSP_ASSERT(lbl, ante, cons, msg)
`define PSP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- rtl/psp_pkg.sv -----
// ----------------------------------------------------------------------------
// psp_pkg
// Types, character codes and helpers shared by the format specification
// parser modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package psp_pkg;

	// characters the parser reacts to
	localparam logic [7:0] CH_ZERO  = 8'h30; // '0'
	localparam logic [7:0] CH_NINE  = 8'h39; // '9'
	localparam logic [7:0] CH_SHARP = 8'h23; // '#'
	localparam logic [7:0] CH_PLUS  = 8'h2B; // '+'
	localparam logic [7:0] CH_MINUS = 8'h2D; // '-'
	localparam logic [7:0] CH_SPACE = 8'h20; // ' '
	localparam logic [7:0] CH_STAR  = 8'h2A; // '*'
	localparam logic [7:0] CH_DOT   = 8'h2E; // '.'
	localparam logic [7:0] CH_H     = 8'h68; // 'h'
	localparam logic [7:0] CH_L     = 8'h6C; // 'l'
	localparam logic [7:0] CH_J     = 8'h6A; // 'j'
	localparam logic [7:0] CH_Z     = 8'h7A; // 'z'

	// flag bit positions
	localparam int FBIT_ZERO  = 0;
	localparam int FBIT_SHARP = 1;
	localparam int FBIT_PLUS  = 2;
	localparam int FBIT_MINUS = 3;
	localparam int FBIT_SPACE = 4;

	// length modifier codes
	localparam logic [2:0] LEN_NONE = 3'd0;
	localparam logic [2:0] LEN_H    = 3'd1;
	localparam logic [2:0] LEN_HH   = 3'd2;
	localparam logic [2:0] LEN_L    = 3'd3;
	localparam logic [2:0] LEN_LL   = 3'd4;
	localparam logic [2:0] LEN_J    = 3'd5;
	localparam logic [2:0] LEN_Z    = 3'd6;

	// 32-bit signed limits
	localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] S32_MIN = 32'h8000_0000;
	localparam logic signed [35:0] S32_MAX_X = 36'sh0_7FFF_FFFF;
	localparam logic signed [35:0] S32_MIN_X = 36'shF_8000_0000;

	// parse phase, one-hot
	typedef enum logic [4:0] {
		PH_FLAGS = 5'b00001,
		PH_WIDTH = 5'b00010,
		PH_PREC  = 5'b00100,
		PH_LEN1  = 5'b01000,
		PH_LEN2  = 5'b10000
	} psp_phase_t;

	typedef struct packed {
		logic [7:0]         spec_char;
		logic signed [31:0] star_arg;
	} psp_in_t;

	typedef struct packed {
		logic [4:0]         flag_bits;
		logic               has_width;
		logic signed [31:0] field_width;
		logic               left_align;
		logic               has_precision;
		logic signed [31:0] precision_value;
		logic [2:0]         length_code;
		logic [7:0]         conversion;
	} psp_out_t;

	typedef struct packed {
		psp_phase_t  phase;
		logic [4:0]  flags_seen;
		logic [31:0] width_acc;
		logic        width_seen;
		logic        left_seen;
		logic [31:0] prec_acc;
		logic        prec_seen;
		logic        prec_negative;
		logic        star_pending;
		logic        prec_first;
		logic [2:0]  length_held;
	} psp_state_t;

	localparam psp_state_t STATE_RESET = '{phase: PH_FLAGS, default: '0};

	// acc * 10 + digit, clamped to the signed 32-bit range
	function automatic logic [31:0] sat_digit(input logic [31:0] acc, input logic [3:0] d);
		logic signed [35:0] a;
		logic signed [35:0] v;
		a = {{4{acc[31]}}, acc};
		v = (a <<< 3) + (a <<< 1) + $signed({32'd0, d});
		if (v > S32_MAX_X)
			return S32_MAX;
		else if (v < S32_MIN_X)
			return S32_MIN;
		else
			return v[31:0];
	endfunction

endpackage

`default_nettype wire

// ----- rtl/psp_step.sv -----
// ----------------------------------------------------------------------------
// psp_step
// One parse step: classifies a character against the current parse state,
// gives the next state and, on the conversion character, the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module psp_step import psp_pkg::*; (
	input  psp_state_t cur,
	input  psp_in_t    item,
	output psp_state_t nxt,
	output logic       emit,
	output psp_out_t   result
);

	always_comb begin
		logic [7:0]  c;
		logic [31:0] star;
		logic [31:0] star_abs;
		logic [7:0]  dig;
		logic        is_dig;
		logic [4:0]  fbit;
		psp_phase_t  p;
		logic        taken;

		c      = item.spec_char;
		star   = item.star_arg;
		dig    = c - CH_ZERO;
		is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
		// absolute value of the star argument, clamped
		star_abs = star[31] ? ((star == S32_MIN) ? S32_MAX : (~star + 32'd1)) : star;

		nxt    = cur;
		emit   = 1'b0;
		result = '0;
		taken  = 1'b0;
		fbit   = '0;
		p      = cur.phase;

		// flags
		if (p == PH_FLAGS) begin
			case (c)
				CH_ZERO:  fbit[FBIT_ZERO]  = 1'b1;
				CH_SHARP: fbit[FBIT_SHARP] = 1'b1;
				CH_PLUS:  fbit[FBIT_PLUS]  = 1'b1;
				CH_MINUS: fbit[FBIT_MINUS] = 1'b1;
				CH_SPACE: fbit[FBIT_SPACE] = 1'b1;
				default:  fbit = '0;
			endcase
			if (fbit != '0) begin
				nxt.flags_seen = cur.flags_seen | fbit;
				taken = 1'b1;
			end else begin
				p = PH_WIDTH;
			end
		end

		// width
		if (!taken && p == PH_WIDTH) begin
			if (c == CH_STAR) begin
				nxt.width_acc    = star_abs;
				nxt.left_seen    = cur.left_seen | star[31];
				nxt.star_pending = 1'b1;
				nxt.width_seen   = 1'b1;
				nxt.phase        = p;
				taken = 1'b1;
			end else if (is_dig) begin
				nxt.width_acc    = sat_digit(cur.star_pending ? 32'd0 : cur.width_acc,
					dig[3:0]);
				nxt.star_pending = 1'b0;
				nxt.width_seen   = 1'b1;
				nxt.phase        = p;
				taken = 1'b1;
			end else if (c == CH_DOT) begin
				nxt.phase         = PH_PREC;
				nxt.prec_seen     = 1'b1;
				nxt.prec_first    = 1'b1;
				nxt.prec_acc      = '0;
				nxt.prec_negative = 1'b0;
				nxt.star_pending  = 1'b0;
				taken = 1'b1;
			end
		end

		// precision
		if (!taken && p == PH_PREC) begin
			if (cur.prec_first && c == CH_STAR) begin
				nxt.prec_acc      = star;
				nxt.prec_negative = cur.prec_negative | star[31];
				nxt.star_pending  = 1'b1;
				nxt.prec_first    = 1'b0;
				taken = 1'b1;
			end else if (cur.prec_first && c == CH_MINUS) begin
				nxt.prec_negative = 1'b1;
				nxt.prec_first    = 1'b0;
				taken = 1'b1;
			end else if (is_dig) begin
				nxt.prec_acc     = sat_digit(cur.star_pending ? 32'd0 : cur.prec_acc,
					dig[3:0]);
				nxt.star_pending = 1'b0;
				nxt.prec_first   = 1'b0;
				taken = 1'b1;
			end
		end

		// first length letter
		if (!taken && (p == PH_FLAGS || p == PH_WIDTH || p == PH_PREC)) begin
			case (c)
				CH_H: begin
					nxt.length_held = LEN_H;
					nxt.phase = PH_LEN1;
					taken = 1'b1;
				end
				CH_L: begin
					nxt.length_held = LEN_L;
					nxt.phase = PH_LEN1;
					taken = 1'b1;
				end
				CH_J: begin
					nxt.length_held = LEN_J;
					nxt.phase = PH_LEN2;
					taken = 1'b1;
				end
				CH_Z: begin
					nxt.length_held = LEN_Z;
					nxt.phase = PH_LEN2;
					taken = 1'b1;
				end
				default: ;
			endcase
		end

		// doubled h or l
		if (!taken && p == PH_LEN1) begin
			if (c == CH_H && cur.length_held == LEN_H) begin
				nxt.length_held = LEN_HH;
				nxt.phase = PH_LEN2;
				taken = 1'b1;
			end else if (c == CH_L && cur.length_held == LEN_L) begin
				nxt.length_held = LEN_LL;
				nxt.phase = PH_LEN2;
				taken = 1'b1;
			end
		end

		// conversion character: build result, clear state
		if (!taken) begin
			emit = 1'b1;
			result.flag_bits     = cur.flags_seen;
			result.has_width     = cur.width_seen;
			result.field_width   = cur.width_seen ? cur.width_acc : 32'd0;
			result.left_align    = cur.left_seen;
			result.has_precision = cur.prec_seen;
			result.length_code   = cur.length_held;
			result.conversion    = c;
			if (cur.prec_seen) begin
				if (!cur.width_seen && cur.prec_negative) begin
					// negative precision with no width turns into the width
					result.field_width   = (cur.prec_acc != '0) ? cur.prec_acc : '1;
					result.left_align    = 1'b1;
					result.has_precision = 1'b0;
				end else if (cur.prec_negative) begin
					result.precision_value = (cur.prec_acc == S32_MIN) ? S32_MAX
						: (~cur.prec_acc + 32'd1);
				end else begin
					result.precision_value = cur.prec_acc;
				end
			end
			nxt = STATE_RESET;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/printf_spec_parser.sv -----
// ----------------------------------------------------------------------------
// printf_spec_parser
// Parses a printf conversion specification, one character per transfer,
// and delivers one result per conversion character.
// ----------------------------------------------------------------------------
// Usage:
//   spec channel: one character of the specification (the text after the
//   percent sign) and the star argument that a '*' character consumes.
//   result channel: flags, width, precision, length and conversion character
//   of a complete specification, one transfer per conversion character.
//   Throughput: one character per cycle while the input is not stalled.
//   A transferred character sits in the input register and is parsed from
//   there; a conversion character's result is loaded into the result register
//   and offered on the result channel; every other character produces no transfer.
//   The parse state updates in one pass through psp_step per character.
//   Reset clears the input valid flag, the parse state and the result valid flag.
//   When the result receiver stalls, the held result stays put; characters
//   that produce no result keep flowing, and the input stalls only when the
//   next conversion character is waiting behind a held result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "printf_spec_parser_macros.svh"

module printf_spec_parser import psp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     spec_valid,
	output logic     spec_stall,
	input  psp_in_t  spec_data,
	output logic     result_valid,
	input  logic     result_stall,
	output psp_out_t result_data
);

	logic       valid_s1;
	psp_in_t    data_s1;
	psp_state_t st_q;
	psp_state_t st_next;
	logic       step_emit;
	psp_out_t   step_result;
	logic       s1_go;
	logic       s1_fire;
	logic       spec_xfer;

	// parse step on the registered character
	psp_step u_step (
		.cur    (st_q),
		.item   (data_s1),
		.nxt    (st_next),
		.emit   (step_emit),
		.result (step_result)
	);

	// the held character may move on unless it needs a result slot that is taken
	assign s1_go      = !step_emit || !result_valid || !result_stall;
	assign s1_fire    = valid_s1 && s1_go;
	assign spec_stall = valid_s1 && !s1_go;
	assign spec_xfer  = spec_valid && !spec_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (spec_xfer) begin
			valid_s1 <= 1'b1;
		end else if (s1_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (spec_xfer) begin
			data_s1 <= spec_data;
		end
	end

	// parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= STATE_RESET;
		end else if (s1_fire) begin
			st_q <= st_next;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (s1_fire && step_emit) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && step_emit) begin
			result_data <= step_result;
		end
	end

	// checks
	`PSP_ASSERT_NEXT(a_clear_after_result, s1_fire && step_emit, st_q == STATE_RESET, "parse state not cleared after a result")
	`PSP_ASSERT_NEXT(a_result_loaded, s1_fire && step_emit, result_valid, "result not offered after conversion character")
	`PSP_ASSERT(a_stall_cause, spec_stall, valid_s1 && step_emit && result_valid && result_stall, "input stalled without a blocked result")
	`PSP_ASSERT(a_width_nonneg, 1'b1, !st_q.width_acc[31], "width accumulator went negative")
	`PSP_ASSERT(a_flags_phase_clean, st_q.phase == PH_FLAGS, !st_q.width_seen && !st_q.prec_seen && st_q.length_held == LEN_NONE, "fields set while still in flags phase")

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for printf_spec_parser. A short table of directed
// characters is followed by randomly built format specifications, mostly
// well formed with some noise. Every result transfer is compared field by
// field against an in-bench parse of the same character stream, under three
// idle patterns on the two channels and one long receiver hold-off.
// ----------------------------------------------------------------------------

module tb;
	import psp_pkg::*;

	localparam int     RAND_ITEMS     = 1400;
	localparam int     LONG_HOLD      = 100;
	localparam int     WATCHDOG_LIMIT = 5000;
	localparam int     MAX_REPORTS    = 10;
	localparam longint SAT_HI         = 64'sd2147483647;
	localparam longint SAT_LO         = -64'sd2147483648;

	localparam psp_out_t NO_RES = '0;

	localparam logic [7:0] FLAG_CHARS [5] = '{CH_ZERO, CH_SHARP, CH_PLUS, CH_MINUS, CH_SPACE};
	localparam logic [7:0] CONV_CHARS [14] = '{"d", "i", "o", "u", "x", "X", "c", "s",
		"p", "f", "e", "%", "h", "l"};

	// one directed character; res is used only where typed is set
	typedef struct packed {
		logic [7:0]         ch;
		logic signed [31:0] star;
		logic               typed;
		psp_out_t           res;
	} dir_row_t;

	localparam dir_row_t DIR_ROWS [26] = '{
		// conversion right after reset
		'{"d", 32'sd0, 1'b1, '{5'h00, 1'b0, 32'sd0, 1'b0, 1'b0, 32'sd0, LEN_NONE, "d"}},
		// every flag
		'{CH_ZERO,  32'sd0, 1'b0, NO_RES},
		'{CH_SHARP, 32'sd0, 1'b0, NO_RES},
		'{CH_PLUS,  32'sd0, 1'b0, NO_RES},
		'{CH_MINUS, 32'sd0, 1'b0, NO_RES},
		'{CH_SPACE, 32'sd0, 1'b0, NO_RES},
		'{"x", 32'sd0, 1'b1, '{5'h1F, 1'b0, 32'sd0, 1'b0, 1'b0, 32'sd0, LEN_NONE, "x"}},
		// most negative width star saturates and sets left alignment
		'{CH_STAR, S32_MIN, 1'b0, NO_RES},
		'{"s", 32'sd0, 1'b1,
			'{5'h00, 1'b1, 32'sh7FFF_FFFF, 1'b1, 1'b0, 32'sd0, LEN_NONE, "s"}},
		// digit after a star restarts the width; negated precision saturates
		'{CH_STAR, 32'sd5, 1'b0, NO_RES},
		'{"3",     32'sd0, 1'b0, NO_RES},
		'{CH_DOT,  32'sd0, 1'b0, NO_RES},
		'{CH_STAR, S32_MIN, 1'b0, NO_RES},
		'{CH_J,    32'sd0, 1'b0, NO_RES},
		'{"s",     32'sd0, 1'b0, NO_RES},
		// negative precision with no width turns into width -1
		'{CH_DOT,   32'sd0, 1'b0, NO_RES},
		'{CH_MINUS, 32'sd0, 1'b0, NO_RES},
		'{"%", 32'sd0, 1'b1, '{5'h00, 1'b0, -32'sd1, 1'b1, 1'b0, 32'sd0, LEN_NONE, "%"}},
		// flag character after a width ends the spec
		'{"7", 32'sd0, 1'b0, NO_RES},
		'{CH_MINUS, 32'sd0, 1'b1, '{5'h00, 1'b1, 32'sd7, 1'b0, 1'b0, 32'sd0, LEN_NONE, "-"}},
		// star past the first precision place ends the spec
		'{CH_DOT,  32'sd0, 1'b0, NO_RES},
		'{"5",     32'sd0, 1'b0, NO_RES},
		'{CH_STAR, 32'sh5A5A_A5A5, 1'b0, NO_RES},
		// ll with a zero byte as conversion
		'{CH_L, 32'sd0, 1'b0, NO_RES},
		'{CH_L, 32'sd0, 1'b0, NO_RES},
		'{8'h00, 32'sd0, 1'b1, '{5'h00, 1'b0, 32'sd0, 1'b0, 1'b0, 32'sd0, LEN_LL, 8'h00}}
	};

	logic     clk;
	logic     arst_n;
	logic     spec_valid;
	logic     spec_stall;
	psp_in_t  spec_data;
	logic     result_valid;
	logic     result_stall;
	psp_out_t result_data;

	printf_spec_parser DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.spec_valid   (spec_valid),
		.spec_stall   (spec_stall),
		.spec_data    (spec_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_data  (result_data)
	);

	// parsed specs waiting for their result transfer
	psp_out_t   parsed_q [$];
	logic [7:0] spec_text [$];

	int tx_idle_pct;
	int rx_idle_pct;
	int hold_req;
	int chars_sent;
	int specs_seen;
	int fail_count;
	int idle_cycles;

	// parse state mirror
	psp_phase_t pp_phase;
	logic [4:0] pp_flags;
	longint     pp_width;
	longint     pp_prec;
	bit         pp_width_seen;
	bit         pp_left;
	bit         pp_prec_seen;
	bit         pp_prec_neg;
	bit         pp_star_pend;
	bit         pp_prec_first;
	logic [2:0] pp_len;

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	function automatic void clear_parse();
		pp_phase      = PH_FLAGS;
		pp_flags      = '0;
		pp_width      = 0;
		pp_prec       = 0;
		pp_width_seen = 1'b0;
		pp_left       = 1'b0;
		pp_prec_seen  = 1'b0;
		pp_prec_neg   = 1'b0;
		pp_star_pend  = 1'b0;
		pp_prec_first = 1'b0;
		pp_len        = LEN_NONE;
	endfunction

	// acc * 10 + digit, clamped to 32-bit signed
	function automatic longint add_decimal(longint acc, logic [7:0] c);
		longint v;
		v = acc * 10 + longint'(c) - longint'(CH_ZERO);
		if (v > SAT_HI)
			v = SAT_HI;
		if (v < SAT_LO)
			v = SAT_LO;
		return v;
	endfunction

	// advance the parse by one character; returns 1 with res on a conversion
	function automatic bit parse_char(input psp_in_t item, output psp_out_t res);
		logic [7:0] c;
		logic [4:0] fbit;
		longint     star;
		longint     fw;
		longint     pv;
		bit         left;
		bit         hp;
		bit         digit;
		c     = item.spec_char;
		star  = item.star_arg;
		digit = (c >= CH_ZERO) && (c <= CH_NINE);
		res   = '0;

		// flags
		if (pp_phase == PH_FLAGS) begin
			fbit = '0;
			case (c)
				CH_ZERO:  fbit[FBIT_ZERO]  = 1'b1;
				CH_SHARP: fbit[FBIT_SHARP] = 1'b1;
				CH_PLUS:  fbit[FBIT_PLUS]  = 1'b1;
				CH_MINUS: fbit[FBIT_MINUS] = 1'b1;
				CH_SPACE: fbit[FBIT_SPACE] = 1'b1;
				default:  fbit = '0;
			endcase
			if (fbit != '0) begin
				pp_flags |= fbit;
				return 1'b0;
			end
			pp_phase = PH_WIDTH;
		end

		// width
		if (pp_phase == PH_WIDTH) begin
			if (c == CH_STAR) begin
				if (star < 0) begin
					star = -star;
					if (star > SAT_HI)
						star = SAT_HI;
					pp_left = 1'b1;
				end
				pp_width      = star;
				pp_star_pend  = 1'b1;
				pp_width_seen = 1'b1;
				return 1'b0;
			end
			if (digit) begin
				if (pp_star_pend) begin
					pp_width     = 0;
					pp_star_pend = 1'b0;
				end
				pp_width      = add_decimal(pp_width, c);
				pp_width_seen = 1'b1;
				return 1'b0;
			end
			if (c == CH_DOT) begin
				pp_phase      = PH_PREC;
				pp_prec_seen  = 1'b1;
				pp_prec_first = 1'b1;
				pp_prec       = 0;
				pp_prec_neg   = 1'b0;
				pp_star_pend  = 1'b0;
				return 1'b0;
			end
		end

		// precision
		if (pp_phase == PH_PREC) begin
			if (pp_prec_first && c == CH_STAR) begin
				pp_prec = star;
				if (star < 0)
					pp_prec_neg = 1'b1;
				pp_star_pend  = 1'b1;
				pp_prec_first = 1'b0;
				return 1'b0;
			end
			if (pp_prec_first && c == CH_MINUS) begin
				pp_prec_neg   = 1'b1;
				pp_prec_first = 1'b0;
				return 1'b0;
			end
			if (digit) begin
				if (pp_star_pend) begin
					pp_prec      = 0;
					pp_star_pend = 1'b0;
				end
				pp_prec       = add_decimal(pp_prec, c);
				pp_prec_first = 1'b0;
				return 1'b0;
			end
		end

		// length letters
		if (pp_phase == PH_WIDTH || pp_phase == PH_PREC) begin
			case (c)
				CH_H: begin
					pp_len   = LEN_H;
					pp_phase = PH_LEN1;
					return 1'b0;
				end
				CH_L: begin
					pp_len   = LEN_L;
					pp_phase = PH_LEN1;
					return 1'b0;
				end
				CH_J: begin
					pp_len   = LEN_J;
					pp_phase = PH_LEN2;
					return 1'b0;
				end
				CH_Z: begin
					pp_len   = LEN_Z;
					pp_phase = PH_LEN2;
					return 1'b0;
				end
				default: ;
			endcase
		end
		if (pp_phase == PH_LEN1) begin
			if ((c == CH_H && pp_len == LEN_H) || (c == CH_L && pp_len == LEN_L)) begin
				pp_len   = (pp_len == LEN_H) ? LEN_HH : LEN_LL;
				pp_phase = PH_LEN2;
				return 1'b0;
			end
		end

		// conversion: assemble the result with the precision quirks
		fw   = pp_width_seen ? pp_width : 0;
		left = pp_left;
		hp   = pp_prec_seen;
		pv   = 0;
		if (pp_prec_seen) begin
			if (!pp_width_seen && pp_prec_neg) begin
				fw   = (pp_prec != 0) ? pp_prec : -1;
				left = 1'b1;
				hp   = 1'b0;
			end else if (pp_prec_neg) begin
				pv = -pp_prec;
				if (pv > SAT_HI)
					pv = SAT_HI;
			end else begin
				pv = pp_prec;
			end
		end
		res.flag_bits       = pp_flags;
		res.has_width       = pp_width_seen;
		res.field_width     = fw[31:0];
		res.left_align      = left;
		res.has_precision   = hp;
		res.precision_value = pv[31:0];
		res.length_code     = pp_len;
		res.conversion      = c;
		clear_parse();
		return 1'b1;
	endfunction

	function automatic string field_diff(psp_out_t e, psp_out_t g);
		string s;
		s = "";
		if (g.flag_bits !== e.flag_bits)
			s = {s, $sformatf(" flag_bits exp %0h got %0h", e.flag_bits, g.flag_bits)};
		if (g.has_width !== e.has_width)
			s = {s, $sformatf(" has_width exp %0b got %0b", e.has_width, g.has_width)};
		if (g.field_width !== e.field_width)
			s = {s, $sformatf(" field_width exp %0d got %0d", e.field_width, g.field_width)};
		if (g.left_align !== e.left_align)
			s = {s, $sformatf(" left_align exp %0b got %0b", e.left_align, g.left_align)};
		if (g.has_precision !== e.has_precision)
			s = {s, $sformatf(" has_precision exp %0b got %0b",
				e.has_precision, g.has_precision)};
		if (g.precision_value !== e.precision_value)
			s = {s, $sformatf(" precision_value exp %0d got %0d",
				e.precision_value, g.precision_value)};
		if (g.length_code !== e.length_code)
			s = {s, $sformatf(" length_code exp %0d got %0d", e.length_code, g.length_code)};
		if (g.conversion !== e.conversion)
			s = {s, $sformatf(" conversion exp %0h got %0h", e.conversion, g.conversion)};
		return s;
	endfunction

	function automatic void report_fail(string msg);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$display("[%0t] mismatch:%s", $time, msg);
	endfunction

	function automatic logic signed [31:0] pick_star();
		case ($urandom_range(0, 5))
			0: return S32_MIN;
			1: return S32_MAX;
			2: return $urandom_range(0, 50);
			3: return -$signed($urandom_range(1, 50));
			default: return $urandom();
		endcase
	endfunction

	// decimal digits, first one nonzero so it is not read as a flag
	function automatic void add_digits(int n);
		for (int k = 0; k < n; k++)
			spec_text.push_back(CH_ZERO + 8'($urandom_range((k == 0) ? 1 : 0, 9)));
	endfunction

	// one character transfer on the spec channel, then update the parse mirror
	task automatic send_char(input logic [7:0] c, input logic signed [31:0] star,
		input bit typed, input psp_out_t typed_res);
		psp_in_t  item;
		psp_out_t res;
		item.spec_char = c;
		item.star_arg  = star;
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			spec_valid <= 1'b0;
			@(posedge clk);
		end
		spec_valid <= 1'b1;
		spec_data  <= item;
		@(posedge clk);
		while (spec_stall)
			@(posedge clk);
		chars_sent++;
		if (parse_char(item, res))
			parsed_q.push_back(typed ? typed_res : res);
	endtask

	// sender pauses until every pending result has been transferred
	task automatic drain();
		spec_valid <= 1'b0;
		while (parsed_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// build one specification, mostly well formed, and send it
	task automatic send_random_spec();
		logic [7:0] ch;
		spec_text.delete();
		if ($urandom_range(0, 19) == 0) begin
			repeat ($urandom_range(1, 6)) spec_text.push_back(8'($urandom_range(0, 255)));
		end else begin
			repeat ($urandom_range(0, 3)) spec_text.push_back(FLAG_CHARS[$urandom_range(0, 4)]);
			// width
			case ($urandom_range(0, 4))
				1: add_digits($urandom_range(1, 3));
				2: spec_text.push_back(CH_STAR);
				3: begin
					spec_text.push_back(CH_STAR);
					add_digits($urandom_range(1, 2));
				end
				4: add_digits($urandom_range(10, 12));
				default: ;
			endcase
			// precision
			case ($urandom_range(0, 5))
				2: begin
					spec_text.push_back(CH_DOT);
					add_digits($urandom_range(0, 3));
				end
				3: begin
					spec_text.push_back(CH_DOT);
					spec_text.push_back(CH_STAR);
					add_digits($urandom_range(0, 1));
				end
				4: begin
					spec_text.push_back(CH_DOT);
					spec_text.push_back(CH_MINUS);
					add_digits($urandom_range(0, 2));
				end
				5: begin
					spec_text.push_back(CH_DOT);
					add_digits($urandom_range(10, 12));
				end
				default: ;
			endcase
			// length
			case ($urandom_range(0, 7))
				2: spec_text.push_back(CH_H);
				3: begin
					spec_text.push_back(CH_H);
					spec_text.push_back(CH_H);
				end
				4: spec_text.push_back(CH_L);
				5: begin
					spec_text.push_back(CH_L);
					spec_text.push_back(CH_L);
				end
				6: spec_text.push_back(CH_J);
				7: spec_text.push_back(CH_Z);
				default: ;
			endcase
			// conversion
			if ($urandom_range(0, 4) == 0)
				spec_text.push_back(8'($urandom_range(0, 255)));
			else
				spec_text.push_back(CONV_CHARS[$urandom_range(0, 13)]);
		end
		foreach (spec_text[i]) begin
			ch = spec_text[i];
			if ($urandom_range(0, 24) == 0)
				ch = 8'($urandom_range(0, 255));
			send_char(ch, (ch == CH_STAR) ? pick_star() : $signed($urandom()), 1'b0, NO_RES);
		end
	endtask

	// result receiver: random stall, or a long hold-off on request
	initial begin : result_receiver
		int hold_left;
		int hold_ack;
		hold_left    = 0;
		hold_ack     = 0;
		result_stall = 1'b1;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				result_stall <= 1'b1;
				hold_left--;
			end else if (hold_ack != hold_req) begin
				hold_ack     = hold_req;
				hold_left    = LONG_HOLD;
				result_stall <= 1'b1;
			end else begin
				result_stall <= ($urandom_range(0, 99) < rx_idle_pct);
			end
		end
	end

	// compare each result transfer with the oldest parsed spec
	always @(posedge clk) begin : result_check
		psp_out_t want;
		string    diff;
		if (arst_n && result_valid && !result_stall) begin
			specs_seen++;
			if (parsed_q.size() == 0) begin
				report_fail($sformatf(" result with nothing pending: %p", result_data));
			end else begin
				want = parsed_q.pop_front();
				diff = field_diff(want, result_data);
				if (diff != "")
					report_fail(diff);
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (spec_valid && !spec_stall) || (result_valid && !result_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL printf_spec_parser");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// main sequence
	initial begin
		arst_n      = 1'b0;
		spec_valid  = 1'b0;
		spec_data   = '0;
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_req    = 0;
		chars_sent  = 0;
		specs_seen  = 0;
		fail_count  = 0;
		idle_cycles = 0;
		clear_parse();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed table
		foreach (DIR_ROWS[i])
			send_char(DIR_ROWS[i].ch, DIR_ROWS[i].star, DIR_ROWS[i].typed, DIR_ROWS[i].res);
		drain();

		// random specs in three idle patterns; long hold-off in the last one
		for (int p = 0; p < 3; p++) begin
			case (p)
				0: begin
					tx_idle_pct = 26;
					rx_idle_pct <= 88;
				end
				1: begin
					tx_idle_pct = 88;
					rx_idle_pct <= 26;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct <= 0;
					hold_req    <= hold_req + 1;
				end
			endcase
			while (chars_sent < $size(DIR_ROWS) + (p + 1) * RAND_ITEMS / 3)
				send_random_spec();
			drain();
		end
		repeat (8) @(posedge clk);

		$display("Sent %0d characters, checked %0d parsed specifications, %0d failures.",
			chars_sent, specs_seen, fail_count);
		if (fail_count == 0)
			$display("PASS printf_spec_parser");
		else
			$display("FAIL printf_spec_parser");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/psp_pkg.sv
rtl/psp_step.sv
rtl/printf_spec_parser.sv
tb/tb.sv
